// ===== rtl/core/hidkb_pkg.sv =====
`timescale 1ns / 1ps

package hidkb_pkg;

    localparam int unsigned MAX_SLOTS         = 6;
    localparam int unsigned KEY_SLOTS_DEFAULT = 6;
    localparam int unsigned CODE_W            = 8;

    localparam logic [CODE_W-1:0] TABLE_SIZE = 8'd104;
    localparam logic [CODE_W-1:0] SHIFT_MASK = 8'h22;

    // special key codes, fixed at build time
    localparam logic [CODE_W-1:0] CHAR_HOME  = 8'h80;
    localparam logic [CODE_W-1:0] CHAR_DEL   = 8'h81;
    localparam logic [CODE_W-1:0] CHAR_END   = 8'h82;
    localparam logic [CODE_W-1:0] CHAR_RIGHT = 8'h83;
    localparam logic [CODE_W-1:0] CHAR_LEFT  = 8'h84;
    localparam logic [CODE_W-1:0] CHAR_DOWN  = 8'h85;
    localparam logic [CODE_W-1:0] CHAR_UP    = 8'h86;

    typedef logic [MAX_SLOTS-1:0][CODE_W-1:0] key_vec_t;

    // usage code below TABLE_SIZE to character; zero where unmapped
    function automatic logic [CODE_W-1:0] map_char(input logic [6:0] code,
                                                   input logic       shifted);
        logic [CODE_W-1:0] wide;
        logic [CODE_W-1:0] ch;
        wide = {1'b0, code};
        ch   = 8'h00;
        unique case (code)
            7'd39:  ch = shifted ? 8'h29 : 8'h30;
            7'd40:  ch = 8'h0A;
            7'd42:  ch = 8'h08;
            7'd43:  ch = 8'h09;
            7'd44:  ch = 8'h20;
            7'd45:  ch = shifted ? 8'h5F : 8'h2D;
            7'd46:  ch = shifted ? 8'h2B : 8'h3D;
            7'd47:  ch = shifted ? 8'h7B : 8'h5B;
            7'd48:  ch = shifted ? 8'h7D : 8'h5D;
            7'd49:  ch = shifted ? 8'h7C : 8'h5C;
            7'd50:  ch = shifted ? 8'h7E : 8'h23;
            7'd51:  ch = shifted ? 8'h3A : 8'h3B;
            7'd52:  ch = shifted ? 8'h40 : 8'h27;
            7'd53:  ch = shifted ? 8'h7E : 8'h60;
            7'd54:  ch = shifted ? 8'h3C : 8'h2C;
            7'd55:  ch = shifted ? 8'h3E : 8'h2E;
            7'd56:  ch = shifted ? 8'h3F : 8'h2F;
            7'd74:  ch = CHAR_HOME;
            7'd76:  ch = CHAR_DEL;
            7'd77:  ch = CHAR_END;
            7'd79:  ch = CHAR_RIGHT;
            7'd80:  ch = CHAR_LEFT;
            7'd81:  ch = CHAR_DOWN;
            7'd82:  ch = CHAR_UP;
            7'd84:  ch = 8'h2F;
            7'd85:  ch = 8'h2A;
            7'd86:  ch = 8'h2D;
            7'd87:  ch = 8'h2B;
            7'd88:  ch = 8'h0A;
            7'd98:  ch = 8'h30;
            7'd99:  ch = 8'h2E;
            7'd100: ch = shifted ? 8'h7C : 8'h5C;
            7'd103: ch = 8'h3D;
            7'd30:  ch = shifted ? 8'h21 : 8'h31;
            7'd31:  ch = shifted ? 8'h22 : 8'h32;
            7'd32:  ch = shifted ? 8'h23 : 8'h33;
            7'd33:  ch = shifted ? 8'h24 : 8'h34;
            7'd34:  ch = shifted ? 8'h25 : 8'h35;
            7'd35:  ch = shifted ? 8'h5E : 8'h36;
            7'd36:  ch = shifted ? 8'h26 : 8'h37;
            7'd37:  ch = shifted ? 8'h2A : 8'h38;
            7'd38:  ch = shifted ? 8'h28 : 8'h39;
            default: begin
                if (wide >= 8'd4 && wide <= 8'd29) begin
                    // letters run contiguously from 'a' / 'A'
                    ch = (shifted ? 8'h41 : 8'h61) + wide - 8'd4;
                end else if (wide >= 8'd89 && wide <= 8'd97) begin
                    // keypad digits one to nine
                    ch = 8'h31 + wide - 8'd89;
                end else begin
                    ch = 8'h00;
                end
            end
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/core/hid_keyboard_report_to_ascii.sv =====
`timescale 1ns / 1ps
// An accepted report beat is held in the input register, and its result then in the result register that drives m_*.
// Throughput: one report per cycle while m_ready holds; the input register and the result
// register form a two-stage pipeline with backpressure chained stage to stage.
// Reset: aresetn, synchronous, active low; empties both stages and clears
// the stored key codes of the previous report to zero.
module hid_keyboard_report_to_ascii #(
    parameter int unsigned KEY_SLOTS = hidkb_pkg::KEY_SLOTS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_modifiers,
    input  logic [7:0] s_key_slot_0,
    input  logic [7:0] s_key_slot_1,
    input  logic [7:0] s_key_slot_2,
    input  logic [7:0] s_key_slot_3,
    input  logic [7:0] s_key_slot_4,
    input  logic [7:0] s_key_slot_5,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_char_code
);

    logic                s1_valid_reg;
    logic [7:0]          s1_mods_reg;
    hidkb_pkg::key_vec_t s1_slots_reg;
    hidkb_pkg::key_vec_t prev_reg;
    logic                out_valid_reg;
    logic [7:0]          out_char_reg;
    logic [7:0]          char_next;
    logic                out_ready;
    logic                s1_advance;

    assign out_ready  = !out_valid_reg || m_ready;
    assign s1_advance = s1_valid_reg && out_ready;
    assign s_ready    = !s1_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            s1_mods_reg  <= s_modifiers;
            s1_slots_reg <= {s_key_slot_5, s_key_slot_4, s_key_slot_3,
                             s_key_slot_2, s_key_slot_1, s_key_slot_0};
        end
    end

    hidkb_decode #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_decode (
        .modifiers (s1_mods_reg),
        .slots     (s1_slots_reg),
        .prev_keys (prev_reg),
        .char_code (char_next)
    );

    // replace the stored codes as the beat leaves the first stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else if (s1_advance) begin
            for (int i = 0; i < hidkb_pkg::MAX_SLOTS; i++) begin
                prev_reg[i] <= (i < KEY_SLOTS) ? s1_slots_reg[i] : 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= s1_valid_reg;
        end
        if (s1_advance) begin
            out_char_reg <= char_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_char_code = out_char_reg;

`ifndef ASSERT_OFF
    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_advance |=> out_valid_reg)
        else $error("first stage advanced but result register is empty");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled while pipeline has room");

    a_prev_tracks_slot0: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_advance |=> (prev_reg[0] == $past(s1_slots_reg[0])))
        else $error("stored key code not updated from advancing beat");
`endif

endmodule

// ===== rtl/core/hidkb_decode.sv =====
`timescale 1ns / 1ps

module hidkb_decode #(
    parameter int unsigned KEY_SLOTS = hidkb_pkg::KEY_SLOTS_DEFAULT
) (
    input  logic [7:0]          modifiers,
    input  hidkb_pkg::key_vec_t slots,
    input  hidkb_pkg::key_vec_t prev_keys,
    output logic [7:0]          char_code
);

    logic [hidkb_pkg::MAX_SLOTS-1:0] is_new;
    logic [7:0]                      pick;
    logic                            shifted;

    // a slot is new when nonzero and absent from every stored code
    always_comb begin
        logic held;
        for (int i = 0; i < hidkb_pkg::MAX_SLOTS; i++) begin
            held = 1'b0;
            for (int j = 0; j < hidkb_pkg::MAX_SLOTS; j++) begin
                if (j < KEY_SLOTS && prev_keys[j] == slots[i]) begin
                    held = 1'b1;
                end
            end
            is_new[i] = (i < KEY_SLOTS) && (slots[i] != 8'd0) && !held;
        end
    end

    // first new slot wins
    always_comb begin
        logic found;
        found = 1'b0;
        pick  = 8'd0;
        for (int i = 0; i < hidkb_pkg::MAX_SLOTS; i++) begin
            if (!found && is_new[i]) begin
                found = 1'b1;
                pick  = slots[i];
            end
        end
    end

    assign shifted = |(modifiers & hidkb_pkg::SHIFT_MASK);

    always_comb begin
        if (pick == 8'd0 || pick >= hidkb_pkg::TABLE_SIZE) begin
            char_code = 8'd0;
        end else begin
            char_code = hidkb_pkg::map_char(pick[6:0], shifted);
        end
    end

endmodule

// ===== dv/hid_keyboard_report_to_ascii_tb.sv =====
`timescale 1ns / 1ps

class char_scoreboard;
    localparam int SLOTS = hidkb_pkg::KEY_SLOTS_DEFAULT;

    logic [7:0] plain_tbl [104];
    logic [7:0] shift_tbl [104];
    logic [7:0] held_keys [hidkb_pkg::MAX_SLOTS];
    logic [7:0] expected_chars [$];
    int         errors;
    int         results_seen;

    function new();
        plain_tbl = '{
            8'h00, 8'h00, 8'h00, 8'h00, 8'h61, 8'h62, 8'h63, 8'h64,
            8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A, 8'h6B, 8'h6C,
            8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74,
            8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A, 8'h31, 8'h32,
            8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
            8'h0A, 8'h00, 8'h08, 8'h09, 8'h20, 8'h2D, 8'h3D, 8'h5B,
            8'h5D, 8'h5C, 8'h23, 8'h3B, 8'h27, 8'h60, 8'h2C, 8'h2E,
            8'h2F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00, hidkb_pkg::CHAR_HOME, 8'h00,
            hidkb_pkg::CHAR_DEL, hidkb_pkg::CHAR_END, 8'h00, hidkb_pkg::CHAR_RIGHT,
            hidkb_pkg::CHAR_LEFT, hidkb_pkg::CHAR_DOWN, hidkb_pkg::CHAR_UP, 8'h00,
            8'h2F, 8'h2A, 8'h2D, 8'h2B,
            8'h0A, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
            8'h38, 8'h39, 8'h30, 8'h2E, 8'h5C, 8'h00, 8'h00, 8'h3D
        };
        shift_tbl = '{
            8'h00, 8'h00, 8'h00, 8'h00, 8'h41, 8'h42, 8'h43, 8'h44,
            8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C,
            8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
            8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h21, 8'h22,
            8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
            8'h0A, 8'h00, 8'h08, 8'h09, 8'h20, 8'h5F, 8'h2B, 8'h7B,
            8'h7D, 8'h7C, 8'h7E, 8'h3A, 8'h40, 8'h7E, 8'h3C, 8'h3E,
            8'h3F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00, hidkb_pkg::CHAR_HOME, 8'h00,
            hidkb_pkg::CHAR_DEL, hidkb_pkg::CHAR_END, 8'h00, hidkb_pkg::CHAR_RIGHT,
            hidkb_pkg::CHAR_LEFT, hidkb_pkg::CHAR_DOWN, hidkb_pkg::CHAR_UP, 8'h00,
            8'h2F, 8'h2A, 8'h2D, 8'h2B,
            8'h0A, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
            8'h38, 8'h39, 8'h30, 8'h2E, 8'h7C, 8'h00, 8'h00, 8'h3D
        };
        foreach (held_keys[i]) held_keys[i] = 8'h00;
        errors       = 0;
        results_seen = 0;
    endfunction

    // predict the character of one accepted report, then roll the held keys
    function void note_report(input logic [7:0] mods, input hidkb_pkg::key_vec_t keys);
        logic [7:0] ch;
        logic [7:0] code;
        bit         picked;
        bit         held;
        bit         shifted;
        int         i;
        int         j;
        ch      = 8'h00;
        picked  = 1'b0;
        shifted = (mods & hidkb_pkg::SHIFT_MASK) != 8'h00;
        for (i = 0; i < SLOTS; i++) begin
            code = keys[i];
            held = 1'b0;
            for (j = 0; j < SLOTS; j++)
                if (held_keys[j] == code) held = 1'b1;
            // first new code decides, even when it maps to nothing
            if (!picked && code != 8'h00 && !held) begin
                picked = 1'b1;
                if (code < hidkb_pkg::TABLE_SIZE)
                    ch = shifted ? shift_tbl[code] : plain_tbl[code];
            end
        end
        for (i = 0; i < hidkb_pkg::MAX_SLOTS; i++)
            held_keys[i] = (i < SLOTS) ? keys[i] : 8'h00;
        expected_chars.push_back(ch);
    endfunction

    task report_mismatch(input string msg);
        errors++;
        $display("%0t: %s", $realtime, msg);
    endtask

    task check_char(input logic [7:0] got);
        logic [7:0] want;
        results_seen++;
        if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("char_code 0x%02h with no report pending", got));
        end else begin
            want = expected_chars.pop_front();
            if (got !== want)
                report_mismatch($sformatf("result %0d: char_code 0x%02h, expected 0x%02h",
                                          results_seen, got, want));
        end
    endtask
endclass

module hid_keyboard_report_to_ascii_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 8;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_modifiers;
    logic [7:0] s_key_slot_0;
    logic [7:0] s_key_slot_1;
    logic [7:0] s_key_slot_2;
    logic [7:0] s_key_slot_3;
    logic [7:0] s_key_slot_4;
    logic [7:0] s_key_slot_5;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_char_code;

    char_scoreboard sb;
    int             tx_idle_pct;
    int             rx_idle_pct;
    bit             hold_results;
    int             cycle_count;

    hid_keyboard_report_to_ascii u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_modifiers  (s_modifiers),
        .s_key_slot_0 (s_key_slot_0),
        .s_key_slot_1 (s_key_slot_1),
        .s_key_slot_2 (s_key_slot_2),
        .s_key_slot_3 (s_key_slot_3),
        .s_key_slot_4 (s_key_slot_4),
        .s_key_slot_5 (s_key_slot_5),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_char_code  (m_char_code)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("hid_keyboard_report_to_ascii verification failed");
            $finish;
        end
    end

    // sample both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_report(s_modifiers, {s_key_slot_5, s_key_slot_4, s_key_slot_3,
                                             s_key_slot_2, s_key_slot_1, s_key_slot_0});
            if (m_valid && m_ready)
                sb.check_char(m_char_code);
        end
    end

    // result side: random stalls, or one long hold-off counted here
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_results = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic hidkb_pkg::key_vec_t pack_slots(input logic [7:0] k0, input logic [7:0] k1,
                                                       input logic [7:0] k2, input logic [7:0] k3,
                                                       input logic [7:0] k4, input logic [7:0] k5);
        return {k5, k4, k3, k2, k1, k0};
    endfunction

    task automatic send_report(input logic [7:0] mods, input hidkb_pkg::key_vec_t keys);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_modifiers  <= mods;
        s_key_slot_0 <= keys[0];
        s_key_slot_1 <= keys[1];
        s_key_slot_2 <= keys[2];
        s_key_slot_3 <= keys[3];
        s_key_slot_4 <= keys[4];
        s_key_slot_5 <= keys[5];
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_for_results();
        while (sb.expected_chars.size() != 0) @(posedge aclk);
    endtask

    // press and release keys the way a typist does, slots shuffled each beat
    task automatic type_reports(input int count);
        logic [7:0]          pressed_q [$];
        hidkb_pkg::key_vec_t keys;
        logic [7:0]          code;
        int                  r;
        int                  pos;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 45 || pressed_q.size() == 0) begin
                if (pressed_q.size() == 6) pressed_q.delete($urandom_range(5));
                r = $urandom_range(99);
                if (r < 80)      code = 8'($urandom_range(4, 103));
                else if (r < 85) code = 8'($urandom_range(1, 3));
                else if (r < 92) code = 8'($urandom_range(104, 255));
                else             code = 8'($urandom_range(1, 255));
                pressed_q.push_back(code);
            end else if (r < 75) begin
                pressed_q.delete($urandom_range(pressed_q.size() - 1));
            end else if (r < 80) begin
                pressed_q.delete();
            end
            keys = '0;
            foreach (pressed_q[k]) begin
                do pos = $urandom_range(5); while (keys[pos] != 8'h00);
                keys[pos] = pressed_q[k];
            end
            send_report(8'($urandom_range(255)), keys);
        end
    endtask

    task automatic noise_reports(input int count);
        hidkb_pkg::key_vec_t keys;
        int                  i;
        repeat (count) begin
            for (i = 0; i < 6; i++)
                keys[i] = ($urandom_range(99) < 30) ? 8'h00 : 8'($urandom_range(255));
            send_report(8'($urandom_range(255)), keys);
        end
    endtask

    initial begin
        logic [7:0] nav_codes [7];
        int         i;
        nav_codes    = '{8'd74, 8'd76, 8'd77, 8'd79, 8'd80, 8'd81, 8'd82};
        sb           = new();
        tx_idle_pct  = 25;
        rx_idle_pct  = 25;
        hold_results = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_modifiers  = 8'h00;
        s_key_slot_0 = 8'h00;
        s_key_slot_1 = 8'h00;
        s_key_slot_2 = 8'h00;
        s_key_slot_3 = 8'h00;
        s_key_slot_4 = 8'h00;
        s_key_slot_5 = 8'h00;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_report(8'h00, pack_slots(0, 0, 0, 0, 0, 0));
        send_report(8'h00, pack_slots(4, 0, 0, 0, 0, 0));
        send_report(8'h00, pack_slots(4, 0, 0, 0, 0, 0));
        send_report(8'h02, pack_slots(4, 5, 0, 0, 0, 0));
        send_report(8'h20, pack_slots(0, 0, 0, 0, 0, 39));
        // non-shift modifier bits select nothing
        send_report(8'hDD, pack_slots(30, 0, 0, 0, 0, 0));
        // out-of-table pick blocks the mapped key behind it
        send_report(8'h00, pack_slots(255, 4, 0, 0, 0, 0));
        send_report(8'h00, pack_slots(255, 104, 5, 0, 0, 0));
        send_report(8'hFF, pack_slots(103, 0, 0, 0, 0, 0));
        send_report(8'h22, pack_slots(100, 0, 0, 0, 0, 0));
        send_report(8'h00, pack_slots(1, 6, 0, 0, 0, 0));
        send_report(8'h00, pack_slots(7, 7, 7, 7, 7, 7));
        send_report(8'h00, pack_slots(7, 8, 8, 0, 0, 0));
        for (i = 0; i < 7; i++)
            send_report(i[0] ? 8'h22 : 8'h00, pack_slots(nav_codes[i], 0, 0, 0, 0, 0));
        send_report(8'hFF, pack_slots(255, 255, 255, 255, 255, 255));
        send_report(8'h00, pack_slots(57, 56, 0, 0, 0, 0));
        send_report(8'h20, pack_slots(57, 53, 0, 0, 0, 0));

        type_reports(300);

        // hold the result side off and keep offering beats until input stalls
        tx_idle_pct  = 0;
        hold_results = 1'b1;
        type_reports(40);

        rx_idle_pct = 0;
        type_reports(200);

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_for_results();

        tx_idle_pct = 25;
        rx_idle_pct = 25;
        noise_reports(150);
        type_reports(200);

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_chars.size() == 0) begin
            $display("hid_keyboard_report_to_ascii verification clean");
        end else begin
            $display("hid_keyboard_report_to_ascii verification failed");
        end
        $finish;
    end

endmodule
